@@ src/picture_unit_cpu_register_port_assert.svh @@
// Assertion macros shared by the picture unit register port checker.
`ifndef PICTURE_UNIT_CPU_REGISTER_PORT_ASSERT_SVH
`define PICTURE_UNIT_CPU_REGISTER_PORT_ASSERT_SVH

// Checked on every edge outside reset.
`define PUCRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PUCRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/pucrp_pkg.sv @@
// Command codes and constants of the picture unit register port.
package pucrp_pkg;

  typedef enum logic [3:0] {
    CMD_CTRL_WR   = 4'd0,
    CMD_MASK_WR   = 4'd1,
    CMD_STATUS_RD = 4'd2,
    CMD_OAM_ADDR  = 4'd3,
    CMD_OAM_WR    = 4'd4,
    CMD_OAM_RD    = 4'd5,
    CMD_SCROLL    = 4'd6,
    CMD_VADDR     = 4'd7,
    CMD_VDATA_WR  = 4'd8,
    CMD_VDATA_RD  = 4'd9,
    CMD_STATUS_SET = 4'd10,
    CMD_DMA       = 4'd11
  } cmd_t;

  localparam logic [7:0]  CTRL_RST   = 8'd0;
  localparam logic [7:0]  MASK_RST   = 8'd30;
  localparam logic [7:0]  STATUS_RST = 8'd160;
  localparam logic [14:0] STEP_ONE   = 15'h0001;
  localparam logic [14:0] STEP_ROW   = 15'h0020;
  localparam logic [13:0] PALETTE_BASE = 14'h3F00;
  localparam int unsigned CTRL_INC_BIT = 2;

endpackage

@@ src/picture_unit_cpu_register_port.sv @@
// Picture unit CPU register port: input register, update pass, result register.
// An accepted beat is held in the input register, then its result in the result
// register. Throughput: one beat per cycle unless the result stage is stalled,
// set by the single register-to-register update pass and the sprite RAM's one
// write port and one registered read port.
// Reset (rst_n low, synchronous): both stages empty, registers to power-on
// values, sprite table reads as zero through valid bits cleared.
module picture_unit_cpu_register_port
  import pucrp_pkg::*;
#(
  parameter int OAM_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_cmd,
  input  logic [7:0]  in_wdata,
  input  logic [7:0]  in_dma_index,
  input  logic [7:0]  in_vram_rdata,
  input  logic        in_vblank_edge,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [13:0] out_vram_access_addr,
  output logic        out_vram_read,
  output logic        out_vram_write,
  output logic [7:0]  out_vram_wdata,
  output logic [14:0] out_next_vram_addr,
  output logic [14:0] out_temp_addr_out,
  output logic [2:0]  out_fine_x_out,
  output logic [7:0]  out_ctrl_out,
  output logic [7:0]  out_mask_out
);

  localparam int OAM_AW = $clog2(OAM_BYTES);

  // Input stage.
  logic        in_full_r;
  cmd_t        in_cmd_r;
  logic [7:0]  in_wdata_r;
  logic [7:0]  in_dma_index_r;
  logic [7:0]  in_vram_rdata_r;
  logic        in_vblank_edge_r;

  // Architectural registers.
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [7:0]        status_r, status_nxt;
  logic [14:0]       tmp_r, tmp_nxt;
  logic [14:0]       vaddr_r, vaddr_nxt;
  logic [2:0]        fine_x_r, fine_x_nxt;
  logic              toggle_r, toggle_nxt;
  logic [7:0]        rbuf_r, rbuf_nxt;
  logic [OAM_AW-1:0] oam_addr_r, oam_addr_nxt;

  // Per-beat results.
  logic [7:0]  rd;
  logic [13:0] acc;
  logic        did_rd;
  logic        did_wr;
  logic [7:0]  wout;
  logic [14:0] vstep;

  // Sprite table port.
  logic              oam_we;
  logic [OAM_AW-1:0] oam_waddr;
  logic [7:0]        oam_rdata;

  // Result stage.
  logic        out_valid_r;
  logic [7:0]  rd_r;
  logic [13:0] acc_r;
  logic        did_rd_r;
  logic        did_wr_r;
  logic [7:0]  wout_r;
  logic [14:0] vaddr_out_r;
  logic [14:0] tmp_out_r;
  logic [2:0]  fine_x_out_r;
  logic [7:0]  ctrl_out_r;
  logic [7:0]  mask_out_r;

  logic adv;
  logic proc;
  logic accept;

  // Advance the result stage when it is empty or being taken; the held input
  // beat is processed in the same cycle.
  assign adv      = !out_valid_r || !out_stall;
  assign proc     = in_full_r && adv;
  assign in_stall = in_full_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (accept) begin
      in_full_r <= 1'b1;
    end else if (proc) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_cmd_r         <= cmd_t'(in_cmd);
      in_wdata_r       <= in_wdata;
      in_dma_index_r   <= in_dma_index;
      in_vram_rdata_r  <= in_vram_rdata;
      in_vblank_edge_r <= in_vblank_edge;
    end
  end

  assign vstep = ctrl_r[CTRL_INC_BIT] ? STEP_ROW : STEP_ONE;

  // Register update pass. Every next value holds unless a beat is processed.
  always_comb begin
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    status_nxt   = status_r;
    tmp_nxt      = tmp_r;
    vaddr_nxt    = vaddr_r;
    fine_x_nxt   = fine_x_r;
    toggle_nxt   = toggle_r;
    rbuf_nxt     = rbuf_r;
    oam_addr_nxt = oam_addr_r;
    rd           = 8'd0;
    acc          = 14'd0;
    did_rd       = 1'b0;
    did_wr       = 1'b0;
    wout         = 8'd0;
    oam_we       = 1'b0;
    oam_waddr    = oam_addr_r;
    if (proc) begin
      unique case (in_cmd_r)
        CMD_CTRL_WR: begin
          ctrl_nxt        = in_wdata_r;
          tmp_nxt[11:10]  = in_wdata_r[1:0];
        end
        CMD_MASK_WR: begin
          mask_nxt = in_wdata_r;
        end
        CMD_STATUS_RD: begin
          // Drop the vblank flag in the returned byte at frame start.
          rd         = {status_r[7:5] & {!in_vblank_edge_r, 2'b11}, ctrl_r[4:0]};
          toggle_nxt = 1'b1;
          status_nxt = {1'b0, status_r[6:0]};
        end
        CMD_OAM_ADDR: begin
          oam_addr_nxt = in_wdata_r[OAM_AW-1:0];
        end
        CMD_OAM_WR: begin
          oam_we       = 1'b1;
          oam_addr_nxt = oam_addr_r + OAM_AW'(1);
        end
        CMD_OAM_RD: begin
          rd = oam_rdata;
        end
        CMD_SCROLL: begin
          if (toggle_r) begin
            tmp_nxt[4:0] = in_wdata_r[7:3];
            fine_x_nxt   = in_wdata_r[2:0];
            toggle_nxt   = 1'b0;
          end else begin
            tmp_nxt[14:12] = in_wdata_r[2:0];
            tmp_nxt[9:5]   = in_wdata_r[7:3];
            toggle_nxt     = 1'b1;
          end
        end
        CMD_VADDR: begin
          if (toggle_r) begin
            tmp_nxt    = {1'b0, in_wdata_r[5:0], tmp_r[7:0]};
            toggle_nxt = 1'b0;
          end else begin
            tmp_nxt    = {tmp_r[14:8], in_wdata_r};
            vaddr_nxt  = {tmp_r[14:8], in_wdata_r};
            toggle_nxt = 1'b1;
          end
        end
        CMD_VDATA_WR: begin
          acc       = vaddr_r[13:0];
          did_wr    = 1'b1;
          wout      = in_wdata_r;
          vaddr_nxt = vaddr_r + vstep;
        end
        CMD_VDATA_RD: begin
          acc    = vaddr_r[13:0];
          did_rd = 1'b1;
          // Palette space bypasses the read buffer.
          if (vaddr_r[13:0] < PALETTE_BASE) begin
            rd       = rbuf_r;
            rbuf_nxt = in_vram_rdata_r;
          end else begin
            rd = in_vram_rdata_r;
          end
          vaddr_nxt = vaddr_r + vstep;
        end
        CMD_STATUS_SET: begin
          status_nxt = in_wdata_r;
        end
        CMD_DMA: begin
          oam_we    = 1'b1;
          oam_waddr = oam_addr_r + in_dma_index_r[OAM_AW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read address tracks the sprite address the next beat will see.
  pucrp_oam #(.DEPTH(OAM_BYTES)) u_oam (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (oam_we),
    .waddr (oam_waddr),
    .wdata (in_wdata_r),
    .raddr (oam_addr_nxt),
    .rdata (oam_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= CTRL_RST;
      mask_r      <= MASK_RST;
      status_r    <= STATUS_RST;
      tmp_r       <= '0;
      vaddr_r     <= '0;
      fine_x_r    <= '0;
      toggle_r    <= 1'b1;
      rbuf_r      <= '0;
      oam_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_r     <= ctrl_nxt;
      mask_r     <= mask_nxt;
      status_r   <= status_nxt;
      tmp_r      <= tmp_nxt;
      vaddr_r    <= vaddr_nxt;
      fine_x_r   <= fine_x_nxt;
      toggle_r   <= toggle_nxt;
      rbuf_r     <= rbuf_nxt;
      oam_addr_r <= oam_addr_nxt;
      if (proc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load only with a processed beat, hold while stalled.
  always_ff @(posedge clk) begin
    if (proc) begin
      rd_r         <= rd;
      acc_r        <= acc;
      did_rd_r     <= did_rd;
      did_wr_r     <= did_wr;
      wout_r       <= wout;
      vaddr_out_r  <= vaddr_nxt;
      tmp_out_r    <= tmp_nxt;
      fine_x_out_r <= fine_x_nxt;
      ctrl_out_r   <= ctrl_nxt;
      mask_out_r   <= mask_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_data        = rd_r;
  assign out_vram_access_addr = acc_r;
  assign out_vram_read        = did_rd_r;
  assign out_vram_write       = did_wr_r;
  assign out_vram_wdata       = wout_r;
  assign out_next_vram_addr   = vaddr_out_r;
  assign out_temp_addr_out    = tmp_out_r;
  assign out_fine_x_out       = fine_x_out_r;
  assign out_ctrl_out         = ctrl_out_r;
  assign out_mask_out         = mask_out_r;

endmodule

@@ src/pucrp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pucrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/pucrp_oam.sv @@
// Sprite table: RAM plus per-entry valid bits and write-to-read forwarding.
module pucrp_oam #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [DEPTH-1:0] valid_r;
  logic             hit_r;
  logic             vld_r;
  logic [7:0]       fwd_r;
  logic [7:0]       ram_q;

  pucrp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  // RAM returns old data on a same-address write; forward the new byte.
  always_ff @(posedge clk) begin
    hit_r <= we && (waddr == raddr);
    fwd_r <= wdata;
    vld_r <= valid_r[raddr];
  end

  assign rdata = hit_r ? fwd_r : (vld_r ? ram_q : 8'd0);

endmodule

@@ src/pucrp_checker.sv @@
// Port-level checker for the picture unit register port, bound to the top.
`include "picture_unit_cpu_register_port_assert.svh"

module pucrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [3:0]  in_cmd,
  input logic [7:0]  in_wdata,
  input logic [7:0]  in_dma_index,
  input logic [7:0]  in_vram_rdata,
  input logic        in_vblank_edge,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_data,
  input logic [13:0] out_vram_access_addr,
  input logic        out_vram_read,
  input logic        out_vram_write,
  input logic [7:0]  out_vram_wdata,
  input logic [14:0] out_next_vram_addr,
  input logic [14:0] out_temp_addr_out,
  input logic [2:0]  out_fine_x_out,
  input logic [7:0]  out_ctrl_out,
  input logic [7:0]  out_mask_out
);

  `PUCRP_ASSERT(a_hold_stalled, out_valid && out_stall |=> out_valid && $stable(out_read_data), "stalled result changed")
  `PUCRP_ASSERT(a_rd_wr_excl, out_valid |-> !(out_vram_read && out_vram_write), "video read and write in one beat")
  `PUCRP_ASSERT(a_step_one, out_valid && out_vram_write && !out_ctrl_out[2] |-> out_next_vram_addr[13:0] == out_vram_access_addr + 14'd1, "video address did not advance by one")
  `PUCRP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind picture_unit_cpu_register_port pucrp_checker u_pucrp_checker (.*);
